/* rtl/dtp_pkg.sv */
// ----------------------------------------------------------------------------
// dtp_pkg
// Shared types and constants for the date-time text parser: field widths,
// character codes and the field stage encoding.
// ----------------------------------------------------------------------------
package dtp_pkg;

    // Width of each time field (hour, minute, second, millisecond)
    localparam int TIME_BITS  = 16;
    localparam int YEAR_BITS  = 14;
    localparam int MONTH_BITS = 7;
    localparam int DAY_BITS   = 7;

    // Accumulator must hold a four-digit year as well as a time field
    localparam int ACC_BITS   = (TIME_BITS > YEAR_BITS) ? TIME_BITS : YEAR_BITS;

    // Result packing
    localparam int OUT_BITS   = YEAR_BITS + MONTH_BITS + DAY_BITS + 4 * TIME_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;
    localparam int CHAR_BITS  = 8;

    // Character codes
    localparam logic [CHAR_BITS-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_BITS-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CHAR_BITS-1:0] CHAR_DOT   = 8'h2E;

    // Digit limits of the date fields
    localparam logic [2:0] YEAR_DIGITS = 3'd4;
    localparam logic [2:0] DATE_DIGITS = 3'd2;

    // Field being filled
    typedef enum logic [2:0] {
        STG_YEAR   = 3'd0,
        STG_MONTH  = 3'd1,
        STG_DAY    = 3'd2,
        STG_HOUR   = 3'd3,
        STG_MINUTE = 3'd4,
        STG_SECOND = 3'd5,
        STG_MILLI  = 3'd6,
        STG_DONE   = 3'd7
    } stage_t;

endpackage

/* rtl/datetime_text_parser.sv */
// ----------------------------------------------------------------------------
// datetime_text_parser
// Parses a zero-terminated date-time string, one character per beat, into
// year, month, day, hour, minute, second and millisecond fields.
// ----------------------------------------------------------------------------
//  Channel  | Dir | tdata fields (lowest bit up)                | Beat
//  ---------+-----+---------------------------------------------+----------------
//  s_       | in  | char_code[7:0]                              | one character
//  m_       | out | year, month, day, hour, minute, second, ms  | one per string
//
//  One character is taken per cycle while no terminator stalls; the field
//  update is a single multiply-by-ten and add on the registered character,
//  and a new character may enter as the held one is consumed.
//  Reset (aresetn low, synchronous) clears all field state and empties both
//  the input and the result register.
//  A terminator stalls the input register only while an earlier result still
//  waits in the result register; other characters never stall.
// ----------------------------------------------------------------------------
module datetime_text_parser (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [dtp_pkg::CHAR_BITS-1:0]      s_tdata,  // char_code[7:0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // year_value[13:0], month_value[20:14], day_value[27:21],
    // hour_value[43:28], minute_value[59:44], second_value[75:60],
    // milli_value[91:76], zero fill above
    output logic [dtp_pkg::OUT_TDATA_BITS-1:0] m_tdata
);
    import dtp_pkg::*;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam int MUL_BITS = ACC_BITS + 4;

    // Input register
    logic                  in_vld_reg;
    logic [CHAR_BITS-1:0]  in_char_reg;

    // Field state
    stage_t                stage_reg, stage_next;
    logic [ACC_BITS-1:0]   acc_reg, acc_next;
    logic [2:0]            cnt_reg, cnt_next;
    logic [YEAR_BITS-1:0]  year_reg, year_next;
    logic [MONTH_BITS-1:0] month_reg, month_next;
    logic [DAY_BITS-1:0]   day_reg, day_next;
    logic [TIME_BITS-1:0]  hour_reg, hour_next;
    logic [TIME_BITS-1:0]  minute_reg, minute_next;
    logic [TIME_BITS-1:0]  second_reg, second_next;

    // Result register
    logic                      m_vld_reg;
    logic [OUT_TDATA_BITS-1:0] m_data_reg, m_data_next;

    logic                 is_digit;
    logic                 is_sep;
    logic                 is_nul;
    logic [3:0]           digit;
    logic [MUL_BITS-1:0]  mul;
    logic [TIME_BITS-1:0] sat;
    logic [2:0]           limit;
    logic [TIME_BITS-1:0] milli;
    logic                 out_free;
    logic                 consume;

    // Classify the held character
    assign is_nul   = (in_char_reg == CHAR_NUL);
    assign is_digit = (in_char_reg >= CHAR_ZERO) && (in_char_reg <= CHAR_NINE);
    assign is_sep   = (in_char_reg == CHAR_COLON) || (in_char_reg == CHAR_DOT) || is_nul;
    assign digit    = is_digit ? 4'(in_char_reg - CHAR_ZERO) : 4'd0;

    // Decimal accumulate and time-field saturation
    assign mul   = MUL_BITS'(acc_reg) * MUL_BITS'(10) + MUL_BITS'(digit);
    assign sat   = (mul > MUL_BITS'(TIME_MAX)) ? TIME_MAX : mul[TIME_BITS-1:0];
    assign limit = (stage_reg == STG_YEAR) ? YEAR_DIGITS : DATE_DIGITS;

    // Handshake: a terminator needs room in the result register
    assign out_free = !m_vld_reg || m_tready;
    assign consume  = in_vld_reg && (!is_nul || out_free);
    assign s_tready = !in_vld_reg || consume;
    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;

    // Next field state for the held character
    always_comb begin
        stage_next  = stage_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;

        case (stage_reg)
            STG_YEAR, STG_MONTH, STG_DAY: begin
                if (is_digit && (cnt_reg < limit)) begin
                    acc_next = mul[ACC_BITS-1:0];
                    cnt_next = cnt_reg + 3'd1;
                end else begin
                    // close the date field; a surplus digit opens the next one
                    case (stage_reg)
                        STG_YEAR:  year_next  = acc_reg[YEAR_BITS-1:0];
                        STG_MONTH: month_next = acc_reg[MONTH_BITS-1:0];
                        default:   day_next   = acc_reg[DAY_BITS-1:0];
                    endcase
                    acc_next   = ACC_BITS'(digit);
                    cnt_next   = is_digit ? 3'd1 : 3'd0;
                    stage_next = stage_t'(stage_reg + 3'd1);
                end
            end
            STG_HOUR, STG_MINUTE, STG_SECOND, STG_MILLI: begin
                if (is_digit) begin
                    acc_next = ACC_BITS'(sat);
                end else if (is_sep) begin
                    case (stage_reg)
                        STG_HOUR:   hour_next   = acc_reg[TIME_BITS-1:0];
                        STG_MINUTE: minute_next = acc_reg[TIME_BITS-1:0];
                        STG_SECOND: second_next = acc_reg[TIME_BITS-1:0];
                        default:    ;
                    endcase
                    // millisecond stays in the accumulator
                    if (stage_reg != STG_MILLI) begin
                        acc_next = '0;
                    end
                    cnt_next   = 3'd0;
                    stage_next = stage_t'(stage_reg + 3'd1);
                end
            end
            default: ;
        endcase
    end

    // Pack the result from the updated fields
    always_comb begin
        milli       = (stage_next == STG_DONE) ? acc_next[TIME_BITS-1:0] : '0;
        m_data_next = OUT_TDATA_BITS'({milli, second_next, minute_next, hour_next,
                                       day_next, month_next, year_next});
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
        end
    end

    // Field state: advance per character, clear at the terminator
    always_ff @(posedge aclk) begin
        if (!aresetn || (consume && is_nul)) begin
            stage_reg  <= STG_YEAR;
            acc_reg    <= '0;
            cnt_reg    <= 3'd0;
            year_reg   <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
        end else if (consume) begin
            stage_reg  <= stage_next;
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
        end
    end

    // Result register: load at the terminator, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (consume && is_nul) begin
            m_vld_reg <= 1'b1;
        end else if (m_tready) begin
            m_vld_reg <= 1'b0;
        end
        if (consume && is_nul) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

/* test/datetime_text_parser_tb.sv */
// ----------------------------------------------------------------------------
// datetime_text_parser_tb
// Streams zero-terminated date-time strings into the parser one character per
// beat. A built-in parser model predicts each result. The receiver compares
// every result beat field by field against the oldest prediction. Both sides
// idle at random, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module datetime_text_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dtp_pkg::*;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          TARGET_CHARS = 780;
    localparam int          LONG_HOLD    = 300;
    localparam int          DRAIN_CYCLES = 20;
    localparam int unsigned TIME_MAX     = 32'((64'd1 << TIME_BITS) - 64'd1);

    // One parsed date-time, laid out like the low bits of m_tdata
    typedef struct packed {
        logic [TIME_BITS-1:0]  milli;
        logic [TIME_BITS-1:0]  second;
        logic [TIME_BITS-1:0]  minute;
        logic [TIME_BITS-1:0]  hour;
        logic [DAY_BITS-1:0]   day;
        logic [MONTH_BITS-1:0] month;
        logic [YEAR_BITS-1:0]  year;
    } date_fields_t;

    typedef enum logic [1:0] {
        RCV_ALWAYS,
        RCV_COIN,
        RCV_SPARSE,
        RCV_PERIODIC
    } ready_mode_t;

    logic                      aclk     = 1'b0;
    logic                      aresetn  = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [CHAR_BITS-1:0]      s_tdata  = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_tdata;

    logic [CHAR_BITS-1:0] char_queue[$];
    date_fields_t         pending_dates[$];

    // Parser model state
    stage_t               cur_stage;
    logic [ACC_BITS-1:0]  accum;
    logic [2:0]           ndigits;
    logic [YEAR_BITS-1:0] year_q;
    logic [MONTH_BITS-1:0] month_q;
    logic [DAY_BITS-1:0]  day_q;
    logic [TIME_BITS-1:0] hour_q;
    logic [TIME_BITS-1:0] minute_q;
    logic [TIME_BITS-1:0] second_q;

    int           cycle_count;
    int           chars_sent;
    int           strings_sent;
    int           results_seen;
    int           mismatches;
    int           input_stalls;
    int           burst_left;
    int           gap_left;
    int           hold_left;
    int           pattern_left;
    bit           long_hold_done;
    ready_mode_t  ready_mode;
    date_fields_t new_date;
    date_fields_t got_date;
    date_fields_t want_date;

    datetime_text_parser u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------
    function automatic void clear_parse();
        cur_stage = STG_YEAR;
        accum     = '0;
        ndigits   = '0;
        year_q    = '0;
        month_q   = '0;
        day_q     = '0;
        hour_q    = '0;
        minute_q  = '0;
        second_q  = '0;
    endfunction

    function automatic void latch_field(stage_t stg, int unsigned value);
        case (stg)
            STG_YEAR:   year_q   = value[YEAR_BITS-1:0];
            STG_MONTH:  month_q  = value[MONTH_BITS-1:0];
            STG_DAY:    day_q    = value[DAY_BITS-1:0];
            STG_HOUR:   hour_q   = value[TIME_BITS-1:0];
            STG_MINUTE: minute_q = value[TIME_BITS-1:0];
            STG_SECOND: second_q = value[TIME_BITS-1:0];
            default: ;
        endcase
    endfunction

    // Consume one character; return 1 with the finished fields on a terminator
    function automatic bit parse_char(input logic [CHAR_BITS-1:0] ch,
                                      output date_fields_t res);
        bit                is_digit;
        int unsigned       d;
        longint unsigned   v;
        logic [2:0]        full;
        is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
        d        = is_digit ? 32'(ch - CHAR_ZERO) : 32'd0;
        res      = '0;
        if (cur_stage <= STG_DAY) begin
            full = (cur_stage == STG_YEAR) ? YEAR_DIGITS : DATE_DIGITS;
            if (is_digit && ndigits < full) begin
                accum   = ACC_BITS'(accum * 10 + d);
                ndigits = ndigits + 3'd1;
            end else begin
                // a non-digit or a surplus digit closes the date field
                latch_field(cur_stage, 32'(accum));
                accum     = is_digit ? ACC_BITS'(d) : '0;
                ndigits   = is_digit ? 3'd1 : 3'd0;
                cur_stage = stage_t'(cur_stage + 1);
            end
        end else if (cur_stage != STG_DONE) begin
            if (is_digit) begin
                v     = 64'(accum) * 64'd10 + 64'(d);
                accum = (v > 64'(TIME_MAX)) ? ACC_BITS'(TIME_MAX) : ACC_BITS'(v);
            end else if (ch == CHAR_COLON || ch == CHAR_DOT || ch == CHAR_NUL) begin
                latch_field(cur_stage, 32'(accum));
                if (cur_stage != STG_MILLI) begin
                    accum = '0;
                end
                ndigits   = '0;
                cur_stage = stage_t'(cur_stage + 1);
            end
        end
        if (ch != CHAR_NUL) begin
            return 1'b0;
        end
        res.year   = year_q;
        res.month  = month_q;
        res.day    = day_q;
        res.hour   = hour_q;
        res.minute = minute_q;
        res.second = second_q;
        res.milli  = (cur_stage == STG_DONE) ? accum[TIME_BITS-1:0] : '0;
        clear_parse();
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            char_queue.push_back(s[i]);
        end
    endtask

    task automatic add_digits(ref logic [CHAR_BITS-1:0] text[$], input int n);
        repeat (n) text.push_back(CHAR_BITS'(CHAR_ZERO + $urandom_range(0, 9)));
    endtask

    // Usual length most of the time, otherwise anything in lo..hi
    function automatic int run_length(int usual, int lo, int hi);
        return ($urandom_range(0, 9) < 7) ? usual : $urandom_range(lo, hi);
    endfunction

    // A byte the time stages skip over
    function automatic logic [CHAR_BITS-1:0] filler_char();
        logic [CHAR_BITS-1:0] c;
        do begin
            c = CHAR_BITS'($urandom_range(1, 255));
        end while ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_COLON || c == CHAR_DOT);
        return c;
    endfunction

    function automatic logic [CHAR_BITS-1:0] date_sep();
        case ($urandom_range(0, 5))
            0: return "-";
            1: return "/";
            2: return " ";
            3: return CHAR_COLON;
            4: return CHAR_DOT;
            default: return filler_char();
        endcase
    endfunction

    function automatic logic [CHAR_BITS-1:0] time_sep();
        return $urandom_range(0, 1) ? CHAR_COLON : CHAR_DOT;
    endfunction

    task automatic add_random_string();
        logic [CHAR_BITS-1:0] text[$];
        int style;
        int cut;
        style = $urandom_range(0, 99);
        if (style < 12) begin
            // noise string of arbitrary bytes
            repeat ($urandom_range(0, 30)) text.push_back(CHAR_BITS'($urandom_range(1, 255)));
        end else begin
            // date part; a missing separator lets the next digit overflow
            add_digits(text, run_length(4, 0, 6));
            if ($urandom_range(0, 4) != 0) text.push_back(date_sep());
            add_digits(text, run_length(2, 0, 3));
            if ($urandom_range(0, 4) != 0) text.push_back(date_sep());
            add_digits(text, run_length(2, 0, 3));
            if ($urandom_range(0, 4) != 0) text.push_back($urandom_range(0, 1) ? "T" : " ");
            // hour, minute, second
            for (int f = 0; f < 3; f++) begin
                if ($urandom_range(0, 9) == 0) add_digits(text, $urandom_range(5, 8));
                else add_digits(text, run_length(2, 0, 3));
                if ($urandom_range(0, 9) == 0) begin
                    text.push_back(filler_char());
                    add_digits(text, $urandom_range(0, 2));
                end
                text.push_back(time_sep());
            end
            // milliseconds, sometimes closed and followed by trailing bytes
            if ($urandom_range(0, 14) == 0) add_digits(text, $urandom_range(5, 7));
            else add_digits(text, run_length(3, 0, 4));
            if ($urandom_range(0, 2) == 0) begin
                text.push_back(time_sep());
                repeat ($urandom_range(0, 4)) begin
                    text.push_back($urandom_range(0, 1) ? filler_char()
                                   : CHAR_BITS'(CHAR_ZERO + $urandom_range(0, 9)));
                end
            end
            // truncate some strings at a random point
            if (style < 30 && text.size() > 0) begin
                cut = $urandom_range(0, text.size() - 1);
                while (text.size() > cut) void'(text.pop_back());
            end
        end
        foreach (text[i]) char_queue.push_back(text[i]);
        char_queue.push_back(CHAR_NUL);
        strings_sent++;
    endtask

    // ------------------------------------------------------------------
    // Cycle limit
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_dates.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: send characters in bursts, predict on every accepted beat
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left = $urandom_range(1, 40);
            gap_left   = 0;
        end else begin
            if (s_tvalid && !s_tready) input_stalls++;
            // predict the accepted beat
            if (s_tvalid && s_tready) begin
                chars_sent++;
                if (parse_char(s_tdata, new_date)) pending_dates.push_back(new_date);
            end
            // advance when the slot is free
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (char_queue.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= char_queue.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check result beats and drive the stall pattern
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready       <= 1'b0;
            hold_left      = 0;
            pattern_left   = 0;
            long_hold_done = 1'b0;
            ready_mode     = RCV_ALWAYS;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                got_date = m_tdata[OUT_BITS-1:0];
                if (pending_dates.size() == 0) begin
                    $error("Unexpected result beat: %h", m_tdata);
                    mismatches++;
                end else begin
                    want_date = pending_dates.pop_front();
                    check_field("year_value",   32'(want_date.year),   32'(got_date.year));
                    check_field("month_value",  32'(want_date.month),  32'(got_date.month));
                    check_field("day_value",    32'(want_date.day),    32'(got_date.day));
                    check_field("hour_value",   32'(want_date.hour),   32'(got_date.hour));
                    check_field("minute_value", 32'(want_date.minute), 32'(got_date.minute));
                    check_field("second_value", 32'(want_date.second), 32'(got_date.second));
                    check_field("milli_value",  32'(want_date.milli),  32'(got_date.milli));
                    check_field("zero_fill",    0, 32'(m_tdata >> OUT_BITS));
                end
            end
            // hold off once for a long stretch, otherwise follow the pattern
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!long_hold_done && results_seen >= 6) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
                m_tready       <= 1'b0;
            end else begin
                if (pattern_left <= 0) begin
                    ready_mode   = ready_mode_t'($urandom_range(0, 3));
                    pattern_left = $urandom_range(20, 120);
                end
                pattern_left--;
                case (ready_mode)
                    RCV_ALWAYS:   m_tready <= 1'b1;
                    RCV_COIN:     m_tready <= 1'($urandom_range(0, 1));
                    RCV_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
                    RCV_PERIODIC: m_tready <= cycle_count[2];
                    default:      m_tready <= 1'b1;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of test
    // ------------------------------------------------------------------
    initial begin
        clear_parse();

        // empty string: no field reached
        char_queue.push_back(CHAR_NUL);
        // full fields by overflow, both separators, bytes after the last field
        push_text("9999123123.9:8:7.5");
        char_queue.push_back(8'hFF);
        char_queue.push_back(CHAR_NUL);
        // empty date fields, then a saturating hour
        push_text("/:.0009999999");
        char_queue.push_back(CHAR_NUL);
        strings_sent = 3;

        while (char_queue.size() < TARGET_CHARS) add_random_string();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        wait (char_queue.size() == 0 && !s_tvalid);
        wait (pending_dates.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Parsed %0d strings from %0d characters; %0d results checked.",
                 strings_sent, chars_sent, results_seen);
        $display("Input stalled %0d cycles under back-pressure; %0d mismatches.",
                 input_stalls, mismatches);
        if (mismatches == 0 && pending_dates.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
